FILE: design/mscf_pkg.sv
// Shared types, constants and saturation helper for the Marangoni surface-force source.
package mscf_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int WordW         = 32;
	localparam int RootW         = 32;
	localparam int SqW           = 64;
	localparam int SatInW        = 80;

	typedef logic [2:0][WordW-1:0] vec3_t;

	typedef struct packed {
		vec3_t            g;
		vec3_t            t;
		vec3_t            rhs;
		logic [WordW-2:0] vol;
	} node_t;

	typedef struct packed {
		vec3_t            t;
		vec3_t            rhs;
		logic [WordW-2:0] vol;
		logic [WordW-2:0] mag_s;
	} tail_t;

	typedef struct packed {
		logic vld;
		logic en;
	} dctl_t;

	typedef enum logic [1:0] {
		REG_COEFF = 2'd0,
		REG_NDIMS = 2'd1,
		REG_FLOOR = 2'd2
	} reg_idx_t;

	// clamp a wide signed value into signed 32 bits
	function automatic logic signed [WordW-1:0] sat32(input logic signed [SatInW-1:0] v);
		logic signed [WordW-1:0] r;
		if (&v[SatInW-1:WordW-1] || ~|v[SatInW-1:WordW-1]) begin
			r = $signed(v[WordW-1:0]);
		end else if (v[SatInW-1]) begin
			r = $signed({1'b1, {(WordW-1){1'b0}}});
		end else begin
			r = $signed({1'b0, {(WordW-1){1'b1}}});
		end
		return r;
	endfunction

endpackage

FILE: design/marangoni_surface_force_source_top.sv
// Top level of the Marangoni tangential surface-force source pipeline.
//
// One mesh node enters per clock: an item is taken on every edge where start is
// high (busy always reads low, the pipeline never stops), and its updated
// right-hand side appears on rhs_out_x/y/z once it has passed every stage below
// (Q16.16 at the default FRAC_BITS), marked by a one-cycle done strobe. The receiver must
// take each result in that cycle; nothing is held back. The pipeline is made of the
// 32-stage bit-per-stage square root of the gradient magnitude and the
// FRAC_BITS + 2 stage divider that forms the unit normal (FRAC_BITS + 1 quotient
// steps and a sign/output register), plus eleven stages of squaring, dot
// products, tangent projection and three saturating scale steps.
// Configuration writes (tension_temp_coeff, num_dims, norm_floor) are registered
// and must only be issued while no item is in flight. There is no clearing
// pass after reset.
module marangoni_surface_force_source_top import mscf_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [WordW-1:0]  heavi_grad_x,
	input  logic [WordW-1:0]  heavi_grad_y,
	input  logic [WordW-1:0]  heavi_grad_z,
	input  logic [WordW-1:0]  temp_grad_x,
	input  logic [WordW-1:0]  temp_grad_y,
	input  logic [WordW-1:0]  temp_grad_z,
	input  logic [WordW-2:0]  cell_volume,
	input  logic [WordW-1:0]  rhs_in_x,
	input  logic [WordW-1:0]  rhs_in_y,
	input  logic [WordW-1:0]  rhs_in_z,
	input  logic              wr_en,
	input  logic [1:0]        wr_index,
	input  logic [WordW-1:0]  wr_data,
	output logic              done,
	output logic [WordW-1:0]  rhs_out_x,
	output logic [WordW-1:0]  rhs_out_y,
	output logic [WordW-1:0]  rhs_out_z
);

	localparam int NW      = FRAC_BITS + 2;   // normal component width
	localparam int PW      = NW + WordW;      // n * t product
	localparam int SW      = PW + 2;          // sum of three products
	localparam int NtW     = SW - FRAC_BITS;  // dot product after scaling
	localparam int QW      = NW + NtW;        // n * nt product
	localparam int MW      = 2 * WordW;       // scale products
	localparam int Latency = FRAC_BITS + 45;

	// configuration registers
	logic signed [WordW-1:0] coeff_q;
	logic [1:0]              ndims_q;
	logic [WordW-2:0]        floor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_q <= '0;
			ndims_q <= 2'd3;
			floor_q <= (WordW-1)'(1);
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_COEFF: coeff_q <= $signed(wr_data);
				REG_NDIMS: ndims_q <= wr_data[1:0];
				REG_FLOOR: floor_q <= wr_data[WordW-2:0];
				default: ;
			endcase
		end
	end

	// every edge with start takes an item
	assign busy = 1'b0;

	node_t node_in;
	assign node_in.g   = {heavi_grad_z, heavi_grad_y, heavi_grad_x};
	assign node_in.t   = {temp_grad_z, temp_grad_y, temp_grad_x};
	assign node_in.rhs = {rhs_in_z, rhs_in_y, rhs_in_x};
	assign node_in.vol = cell_volume;

	// stage 1: squares of the indicator gradient
	logic                  vld_s1;
	node_t                 node_s1;
	logic signed [SqW-1:0] sq_s1 [3];
	logic signed [SqW-1:0] sq_d  [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sq_d[i] = $signed(node_in.g[i]) * $signed(node_in.g[i]);
		end
	end

	// stage 2: sum of squares
	logic           vld_s2;
	node_t          node_s2;
	logic [SqW-1:0] sumsq_s2;

	// square root
	logic             sq_vld;
	logic [RootW-1:0] mag;
	node_t            node_sq;

	mscf_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s2),
		.radicand (sumsq_s2),
		.in_side  (node_s2),
		.out_vld  (sq_vld),
		.root     (mag),
		.out_side (node_sq)
	);

	// stage 3: floor test and clamped magnitude
	dctl_t            ctl_s3;
	logic [RootW-1:0] mag_s3;
	vec3_t            g_s3;
	tail_t            tail_s3;

	// normal
	logic              dv_vld;
	logic [2:0][NW-1:0] n_dv;
	tail_t             tail_dv;

	mscf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ctl   (ctl_s3),
		.divisor  (mag_s3),
		.g        (g_s3),
		.in_side  (tail_s3),
		.out_vld  (dv_vld),
		.n        (n_dv),
		.out_side (tail_dv)
	);

	// stages 4..11
	logic                  vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9, vld_s10, vld_s11;
	tail_t                 tail_s4, tail_s5, tail_s6, tail_s7, tail_s8, tail_s9, tail_s10;
	logic [2:0][NW-1:0]    n_s4, n_s5;
	logic signed [PW-1:0]  prod_s4 [3];
	logic signed [NtW-1:0] nt_s5;
	logic signed [QW-1:0]  p_s6    [3];
	logic signed [WordW-1:0] tan_s7 [3];
	logic signed [MW-1:0]  m1_s8   [3];
	logic signed [MW-1:0]  m2_s9   [3];
	logic signed [MW-1:0]  m3_s10  [3];
	logic [WordW-1:0]      out_s11 [3];

	logic signed [PW-1:0]    prod_d [3];
	logic signed [SW-1:0]    acc_d;
	logic signed [QW-1:0]    p_d    [3];
	logic signed [WordW-1:0] tan_d  [3];
	logic signed [MW-1:0]    m1_d   [3];
	logic signed [WordW-1:0] t1_d   [3];
	logic signed [MW-1:0]    m2_d   [3];
	logic signed [WordW-1:0] t2_d   [3];
	logic signed [MW-1:0]    m3_d   [3];
	logic signed [WordW-1:0] t3_d   [3];
	logic [WordW-1:0]        out_d  [3];

	always_comb begin
		acc_d = '0;
		for (int i = 0; i < 3; i++) begin
			prod_d[i] = $signed(n_dv[i]) * $signed(tail_dv.t[i]);
			acc_d     = acc_d + SW'(prod_s4[i]);
			p_d[i]    = $signed(n_s5[i]) * nt_s5;
			// tangent: t - n (n . t), floor shifted
			tan_d[i]  = sat32(SatInW'($signed(tail_s6.t[i]))
			                - SatInW'($signed(p_s6[i][QW-1:FRAC_BITS])));
			m1_d[i]   = coeff_q * tan_s7[i];
			t1_d[i]   = sat32(SatInW'($signed(m1_s8[i][MW-1:FRAC_BITS])));
			m2_d[i]   = t1_d[i] * $signed({1'b0, tail_s8.mag_s});
			t2_d[i]   = sat32(SatInW'($signed(m2_s9[i][MW-1:FRAC_BITS])));
			m3_d[i]   = t2_d[i] * $signed({1'b0, tail_s9.vol});
			t3_d[i]   = sat32(SatInW'($signed(m3_s10[i][MW-1:FRAC_BITS])));
			// update only the leading num_dims components, pass the rest
			if (2'(i) < ndims_q) begin
				out_d[i] = sat32(SatInW'($signed(tail_s10.rhs[i])) + SatInW'(t3_d[i]));
			end else begin
				out_d[i] = tail_s10.rhs[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			ctl_s3  <= '0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
		end else begin
			vld_s1     <= start && !busy;
			vld_s2     <= vld_s1;
			ctl_s3.vld <= sq_vld;
			ctl_s3.en  <= (mag > {1'b0, floor_q});
			vld_s4     <= dv_vld;
			vld_s5     <= vld_s4;
			vld_s6     <= vld_s5;
			vld_s7     <= vld_s6;
			vld_s8     <= vld_s7;
			vld_s9     <= vld_s8;
			vld_s10    <= vld_s9;
			vld_s11    <= vld_s10;
		end
	end

	always_ff @(posedge clk) begin
		node_s1  <= node_in;
		node_s2  <= node_s1;
		sumsq_s2 <= SqW'(sq_s1[0]) + SqW'(sq_s1[1]) + SqW'(sq_s1[2]);

		mag_s3        <= mag;
		g_s3          <= node_sq.g;
		tail_s3.t     <= node_sq.t;
		tail_s3.rhs   <= node_sq.rhs;
		tail_s3.vol   <= node_sq.vol;
		tail_s3.mag_s <= mag[RootW-1] ? {(WordW-1){1'b1}} : mag[WordW-2:0];

		n_s4     <= n_dv;
		tail_s4  <= tail_dv;
		n_s5     <= n_s4;
		tail_s5  <= tail_s4;
		nt_s5    <= acc_d[SW-1:FRAC_BITS];
		tail_s6  <= tail_s5;
		tail_s7  <= tail_s6;
		tail_s8  <= tail_s7;
		tail_s9  <= tail_s8;
		tail_s10 <= tail_s9;
		for (int i = 0; i < 3; i++) begin
			sq_s1[i]   <= sq_d[i];
			prod_s4[i] <= prod_d[i];
			p_s6[i]    <= p_d[i];
			tan_s7[i]  <= tan_d[i];
			m1_s8[i]   <= m1_d[i];
			m2_s9[i]   <= m2_d[i];
			m3_s10[i]  <= m3_d[i];
			out_s11[i] <= out_d[i];
		end
	end

	assign done      = vld_s11;
	assign rhs_out_x = out_s11[0];
	assign rhs_out_y = out_s11[1];
	assign rhs_out_z = out_s11[2];

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##Latency done)
		else $error("item taken but no result after the pipeline latency");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, Latency))
		else $error("result strobe without a matching item");

	a_z_passthru: assert property (@(posedge clk) disable iff (!arst_n)
		done && ndims_q != 2'd3 |-> rhs_out_z == $past(rhs_in_z, Latency))
		else $error("z component altered although not updated");

endmodule

FILE: design/mscf_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module mscf_isqrt import mscf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_vld,
	input  logic [SqW-1:0]   radicand,
	input  node_t            in_side,
	output logic             out_vld,
	output logic [RootW-1:0] root,
	output node_t            out_side
);

	localparam int Steps = RootW;

	logic [Steps-1:0] vld_s;
	logic [SqW-1:0]   rem_s  [Steps];
	logic [RootW-1:0] root_s [Steps];
	node_t            side_s [Steps];

	logic [SqW-1:0]   rem_d  [Steps];
	logic [RootW-1:0] root_d [Steps];
	node_t            side_d [Steps];
	logic [Steps-1:0] vld_d;

	for (genvar k = 0; k < Steps; k++) begin : g_step
		localparam int B = Steps - 1 - k;
		logic [SqW-1:0]   rem_in;
		logic [SqW-1:0]   trial;
		logic [RootW-1:0] root_in;

		if (k == 0) begin : g_first
			assign rem_in    = radicand;
			assign root_in   = '0;
			assign vld_d[k]  = in_vld;
			assign side_d[k] = in_side;
		end else begin : g_next
			assign rem_in    = rem_s[k-1];
			assign root_in   = root_s[k-1];
			assign vld_d[k]  = vld_s[k-1];
			assign side_d[k] = side_s[k-1];
		end

		// try setting this root bit: (Q + 2^B)^2 - Q^2 = Q*2^(B+1) + 2^(2B)
		assign trial     = (SqW'(root_in) << (B + 1)) | (SqW'(1) << (2 * B));
		assign rem_d[k]  = (rem_in >= trial) ? rem_in - trial : rem_in;
		assign root_d[k] = (rem_in >= trial) ? (root_in | (RootW'(1) << B)) : root_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= vld_d;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < Steps; k++) begin
			rem_s[k]  <= rem_d[k];
			root_s[k] <= root_d[k];
			side_s[k] <= side_d[k];
		end
	end

	assign out_vld  = vld_s[Steps-1];
	assign root     = root_s[Steps-1];
	assign out_side = side_s[Steps-1];

endmodule

FILE: design/mscf_div.sv
// Pipelined three-lane restoring divider forming the unit normal.
module mscf_div import mscf_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dctl_t                     in_ctl,
	input  logic [RootW-1:0]          divisor,
	input  vec3_t                     g,
	input  tail_t                     in_side,
	output logic                      out_vld,
	output logic [2:0][FRAC_BITS+1:0] n,
	output tail_t                     out_side
);

	localparam int Steps = FRAC_BITS + 1;
	localparam int RemW  = RootW + 2;

	dctl_t                     ctl_s  [Steps];
	logic [2:0][RemW-1:0]      rem_s  [Steps];
	logic [2:0][FRAC_BITS:0]   q_s    [Steps];
	logic [2:0]                sgn_s  [Steps];
	logic [RootW-1:0]          dsr_s  [Steps];
	tail_t                     side_s [Steps];

	dctl_t                     ctl_d  [Steps];
	logic [2:0][RemW-1:0]      rem_d  [Steps];
	logic [2:0][FRAC_BITS:0]   q_d    [Steps];
	logic [2:0]                sgn_d  [Steps];
	logic [RootW-1:0]          dsr_d  [Steps];
	tail_t                     side_d [Steps];

	logic                      vld_q;
	logic [2:0][FRAC_BITS+1:0] n_q;
	tail_t                     side_q;

	for (genvar k = 0; k < Steps; k++) begin : g_step
		logic [2:0][RemW-1:0]    rin;
		logic [2:0][FRAC_BITS:0] qin;
		logic [2:0]              ge;
		logic [RemW-1:0]         dext;

		if (k == 0) begin : g_first
			for (genvar i = 0; i < 3; i++) begin : g_lane
				assign rin[i] = {2'b00, (g[i][WordW-1] ? (~g[i] + WordW'(1)) : g[i])};
			end
			assign qin       = '0;
			assign sgn_d[k]  = {g[2][WordW-1], g[1][WordW-1], g[0][WordW-1]};
			assign ctl_d[k]  = in_ctl;
			assign dsr_d[k]  = divisor;
			assign side_d[k] = in_side;
		end else begin : g_next
			for (genvar i = 0; i < 3; i++) begin : g_lane
				assign rin[i] = {rem_s[k-1][i][RemW-2:0], 1'b0};
			end
			assign qin       = q_s[k-1];
			assign sgn_d[k]  = sgn_s[k-1];
			assign ctl_d[k]  = ctl_s[k-1];
			assign dsr_d[k]  = dsr_s[k-1];
			assign side_d[k] = side_s[k-1];
		end

		assign dext = {2'b00, dsr_d[k]};

		for (genvar i = 0; i < 3; i++) begin : g_sub
			assign ge[i]       = (rin[i] >= dext);
			assign rem_d[k][i] = ge[i] ? rin[i] - dext : rin[i];
			assign q_d[k][i]   = {qin[i][FRAC_BITS-1:0], ge[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < Steps; k++) begin
				ctl_s[k] <= '0;
			end
			vld_q <= 1'b0;
		end else begin
			for (int k = 0; k < Steps; k++) begin
				ctl_s[k] <= ctl_d[k];
			end
			vld_q <= ctl_s[Steps-1].vld;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < Steps; k++) begin
			rem_s[k]  <= rem_d[k];
			q_s[k]    <= q_d[k];
			sgn_s[k]  <= sgn_d[k];
			dsr_s[k]  <= dsr_d[k];
			side_s[k] <= side_d[k];
		end
		// apply sign, zero the normal at or below the floor
		for (int i = 0; i < 3; i++) begin
			if (!ctl_s[Steps-1].en) begin
				n_q[i] <= '0;
			end else if (sgn_s[Steps-1][i]) begin
				n_q[i] <= -{1'b0, q_s[Steps-1][i]};
			end else begin
				n_q[i] <= {1'b0, q_s[Steps-1][i]};
			end
		end
		side_q <= side_s[Steps-1];
	end

	assign out_vld  = vld_q;
	assign n        = n_q;
	assign out_side = side_q;

endmodule
